// File: hdl/pcbw_pkg.sv
package pcbw_pkg;

  localparam int CNT_W       = 32;
  localparam int BYTES_W     = 48;
  localparam int PKT_BYTES_W = 24;
  localparam int CLASS_W     = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;

  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD      = 3'd0,
    CFG_TOT_CNT_LIM = 3'd1,
    CFG_TOT_BYT_LIM = 3'd2,
    CFG_CLS_CNT_LIM = 3'd3,
    CFG_CLS_BYT_LIM = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [CNT_W-1:0]   count;
    logic [BYTES_W-1:0] bytes;
  } class_entry_t;

  typedef struct packed {
    logic               win_clear;
    logic [CNT_W-1:0]   count_now;
    logic [BYTES_W-1:0] bytes_now;
    logic               count_over;
    logic               bytes_over;
  } tot_res_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a);
    logic [CNT_W-1:0] r;
    r = (a == '1) ? a : a + CNT_W'(1);
    return r;
  endfunction

  function automatic logic [BYTES_W-1:0] sat_add_bytes(input logic [BYTES_W-1:0] a,
                                                       input logic [PKT_BYTES_W-1:0] b);
    logic [BYTES_W:0] s;
    s = {1'b0, a} + (BYTES_W+1)'(b);
    return s[BYTES_W] ? '1 : s[BYTES_W-1:0];
  endfunction

endpackage

// File: hdl/pcbw_class_mem.sv
module pcbw_class_mem #(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic                   clk,
  input  logic                   rd_en,
  input  logic [ADDR_W-1:0]      rd_addr,
  output pcbw_pkg::class_entry_t rd_data,
  input  logic                   wr_en,
  input  logic [ADDR_W-1:0]      wr_addr,
  input  pcbw_pkg::class_entry_t wr_data
);
  import pcbw_pkg::*;

  class_entry_t mem [DEPTH];
  class_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/pcbw_totals.sv
module pcbw_totals (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            tick_en,
  input  logic                            pkt_en,
  input  logic [pcbw_pkg::PKT_BYTES_W-1:0] pkt_bytes,
  input  logic [pcbw_pkg::CNT_W-1:0]       period,
  input  logic [pcbw_pkg::CNT_W-1:0]       count_limit,
  input  logic [pcbw_pkg::BYTES_W-1:0]     bytes_limit,
  output pcbw_pkg::tot_res_t              res
);
  import pcbw_pkg::*;

  logic [CNT_W-1:0]   elapsed_r, elapsed_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [BYTES_W-1:0] bytes_r;
  logic [CNT_W-1:0]   count_base;
  logic [BYTES_W-1:0] bytes_base;

  always_comb begin
    res.win_clear  = elapsed_r > period;
    count_base     = res.win_clear ? '0 : count_r;
    bytes_base     = res.win_clear ? '0 : bytes_r;
    res.count_now  = sat_inc(count_base);
    res.bytes_now  = sat_add_bytes(bytes_base, pkt_bytes);
    res.count_over = res.count_now > count_limit;
    res.bytes_over = res.bytes_now > bytes_limit;

    elapsed_nxt = elapsed_r;
    if (tick_en) begin
      elapsed_nxt = sat_inc(elapsed_r);
    end else if (pkt_en && res.win_clear) begin
      elapsed_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
      count_r   <= '0;
      bytes_r   <= '0;
    end else begin
      elapsed_r <= elapsed_nxt;
      if (pkt_en) begin
        count_r <= res.count_now;
        bytes_r <= res.bytes_now;
      end
    end
  end

endmodule

// File: hdl/per_class_bandwidth_window_limiter.sv
// Per-class fixed-window bandwidth limiter.
//
// Input channel (in_*): one transaction per packet (in_cmd = 0) or per time
// tick (in_cmd = 1). Ticks advance a saturating elapsed counter and return
// nothing. Each packet returns exactly one transaction on out_* carrying the
// total and per-class counts and byte sums after the packet, one flag per
// limit and an overall exceeded flag.
//
// out_valid rises once the accepted packet has passed the update stage and
// then the output register. One transaction is taken every cycle while
// in_stall is low, set by the single read-modify-write pass over the
// class counter RAM: the read is issued at acceptance, update and
// write-back happen in the update stage; same-class writes are forwarded.
//
// Reset (rst_n low, synchronous) loads the register defaults, zeroes the
// totals and elapsed count and marks every class entry empty; no clearing
// pass is run. While out_stall holds a finished result, one more packet
// waits in the update stage with in_stall high. Configuration (cfg_*) is
// to be written only while idle; the block does not enforce this.
module per_class_bandwidth_window_limiter #(
  parameter int CLASS_COUNT = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cmd,
  input  logic [pcbw_pkg::CLASS_W-1:0]      in_packet_class,
  input  logic [pcbw_pkg::PKT_BYTES_W-1:0]  in_packet_bytes,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_exceeded,
  output logic                              out_total_count_over,
  output logic                              out_total_bytes_over,
  output logic                              out_class_count_over,
  output logic                              out_class_bytes_over,
  output logic [pcbw_pkg::CNT_W-1:0]        out_total_count_now,
  output logic [pcbw_pkg::BYTES_W-1:0]      out_total_bytes_now,
  output logic [pcbw_pkg::CNT_W-1:0]        out_class_count_now,
  output logic [pcbw_pkg::BYTES_W-1:0]      out_class_bytes_now,
  input  logic                              cfg_we,
  input  logic [pcbw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcbw_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import pcbw_pkg::*;

  localparam int IDX_W     = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int CLS_EXT_W = 9;

  // configuration
  logic [CNT_W-1:0]   period_r;
  logic [CNT_W-1:0]   tot_cnt_lim_r;
  logic [BYTES_W-1:0] tot_byt_lim_r;
  logic [CNT_W-1:0]   cls_cnt_lim_r;
  logic [BYTES_W-1:0] cls_byt_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r      <= CNT_W'(1000000);
      tot_cnt_lim_r <= '1;
      tot_byt_lim_r <= '1;
      cls_cnt_lim_r <= '1;
      cls_byt_lim_r <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PERIOD:      period_r      <= cfg_wdata[CNT_W-1:0];
        CFG_TOT_CNT_LIM: tot_cnt_lim_r <= cfg_wdata[CNT_W-1:0];
        CFG_TOT_BYT_LIM: tot_byt_lim_r <= cfg_wdata[BYTES_W-1:0];
        CFG_CLS_CNT_LIM: cls_cnt_lim_r <= cfg_wdata[CNT_W-1:0];
        CFG_CLS_BYT_LIM: cls_byt_lim_r <= cfg_wdata[BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // input decode
  logic                 in_acc;
  logic [CLS_EXT_W-1:0] cls_ext;
  logic                 in_in_range;
  logic [IDX_W-1:0]     in_idx;

  assign in_acc      = in_valid & ~in_stall;
  assign cls_ext     = CLS_EXT_W'(in_packet_class);
  assign in_in_range = cls_ext < CLS_EXT_W'(CLASS_COUNT);
  assign in_idx      = cls_ext[IDX_W-1:0];

  // update stage
  logic                   s1_valid_r;
  logic                   s1_cmd_r;
  logic                   s1_in_range_r;
  logic [IDX_W-1:0]       s1_idx_r;
  logic [PKT_BYTES_W-1:0] s1_bytes_r;
  logic                   fwd_r;
  class_entry_t           fwd_data_r;
  logic [CLASS_COUNT-1:0] valid_r, valid_nxt;

  logic         s1_tick, s1_pkt, s1_adv, out_load_ok, mem_we;
  class_entry_t mem_rd_data, cls_old, cls_new;
  tot_res_t     tot;
  logic         cc_over, cb_over;

  logic out_valid_r;

  assign out_load_ok = ~out_valid_r | ~out_stall;
  assign s1_tick     = s1_valid_r & (s1_cmd_r == CMD_TICK);
  assign s1_pkt      = s1_valid_r & (s1_cmd_r == CMD_PACKET);
  assign s1_adv      = s1_tick | (s1_pkt & out_load_ok);
  assign in_stall    = s1_valid_r & ~s1_adv;
  assign mem_we      = s1_adv & s1_pkt & s1_in_range_r;

  pcbw_totals u_totals (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_en     (s1_tick),
    .pkt_en      (s1_adv & s1_pkt),
    .pkt_bytes   (s1_bytes_r),
    .period      (period_r),
    .count_limit (tot_cnt_lim_r),
    .bytes_limit (tot_byt_lim_r),
    .res         (tot)
  );

  pcbw_class_mem #(
    .DEPTH  (CLASS_COUNT),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (in_idx),
    .rd_data (mem_rd_data),
    .wr_en   (mem_we),
    .wr_addr (s1_idx_r),
    .wr_data (cls_new)
  );

  always_comb begin
    // window clear wins, then the write that raced our read, then the RAM if the entry is valid, else zero
    if (tot.win_clear) begin
      cls_old = '0;
    end else if (fwd_r) begin
      cls_old = fwd_data_r;
    end else if (valid_r[s1_idx_r]) begin
      cls_old = mem_rd_data;
    end else begin
      cls_old = '0;
    end
    cls_new.count = sat_inc(cls_old.count);
    cls_new.bytes = sat_add_bytes(cls_old.bytes, s1_bytes_r);
    cc_over = s1_in_range_r & (cls_new.count > cls_cnt_lim_r);
    cb_over = s1_in_range_r & (cls_new.bytes > cls_byt_lim_r);

    valid_nxt = valid_r;
    if (s1_adv && s1_pkt && tot.win_clear) begin
      valid_nxt = '0;
    end
    if (mem_we) begin
      valid_nxt[s1_idx_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      valid_r    <= '0;
    end else begin
      valid_r <= valid_nxt;
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r      <= in_cmd;
      s1_in_range_r <= in_in_range;
      s1_idx_r      <= in_idx;
      s1_bytes_r    <= in_packet_bytes;
      fwd_r         <= mem_we & (in_idx == s1_idx_r);
      fwd_data_r    <= cls_new;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_pkt) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_pkt) begin
      out_exceeded         <= tot.count_over | tot.bytes_over | cc_over | cb_over;
      out_total_count_over <= tot.count_over;
      out_total_bytes_over <= tot.bytes_over;
      out_class_count_over <= cc_over;
      out_class_bytes_over <= cb_over;
      out_total_count_now  <= tot.count_now;
      out_total_bytes_now  <= tot.bytes_now;
      out_class_count_now  <= s1_in_range_r ? cls_new.count : '0;
      out_class_bytes_now  <= s1_in_range_r ? cls_new.bytes : '0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: hdl/pcbw_checker.sv
module pcbw_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              out_exceeded,
  input logic                              out_total_count_over,
  input logic                              out_total_bytes_over,
  input logic                              out_class_count_over,
  input logic                              out_class_bytes_over,
  input logic [pcbw_pkg::CNT_W-1:0]        out_total_count_now,
  input logic [pcbw_pkg::BYTES_W-1:0]      out_total_bytes_now,
  input logic [pcbw_pkg::CNT_W-1:0]        out_class_count_now,
  input logic [pcbw_pkg::BYTES_W-1:0]      out_class_bytes_now
);
  import pcbw_pkg::*;

  // a stalled result stays valid, and its totals and class byte sum stay put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_total_count_now)
      && $stable(out_total_bytes_now) && $stable(out_class_bytes_now))
    else $error("result changed while stalled");

  a_exceeded_or: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_exceeded == (out_total_count_over | out_total_bytes_over
      | out_class_count_over | out_class_bytes_over))
    else $error("exceeded flag does not match the limit flags");

  // a class is a subset of the total within one window
  a_class_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_class_count_now <= out_total_count_now)
      && (out_class_bytes_now <= out_total_bytes_now))
    else $error("class sum above total sum");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_total_count_now != '0)
    else $error("packet result with zero total count");

endmodule

bind per_class_bandwidth_window_limiter pcbw_checker u_pcbw_checker (.*);
